// File: rtl/rrd_pkg.sv
// shared widths, constants and controller/datapath interface types
package rrd_pkg;

  // channel and count sizing
  localparam int ChanBits  = 8;
  localparam int CountBits = 22;
  localparam int CntW      = CountBits + 1;
  localparam int SqW       = 2 * ChanBits;
  localparam int TermW     = SqW + 2;
  localparam int SumW      = 40;
  localparam int FracBits  = 16;
  localparam int DivW      = SumW + FracBits;
  localparam int RootW     = DivW / 2;
  localparam int RemW      = RootW + 3;
  localparam int RmsW      = 17;
  localparam int StepW     = $clog2(DivW);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic emit;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_seen;
    logic out_busy;
  } ctl_sts_t;

endpackage

// File: rtl/rrd_datapath.sv
// accumulation stages, shared divide/square-root registers and output register
module rrd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_accept_i,
  input  logic [rrd_pkg::ChanBits-1:0]      red_a_i,
  input  logic [rrd_pkg::ChanBits-1:0]      green_a_i,
  input  logic [rrd_pkg::ChanBits-1:0]      blue_a_i,
  input  logic                              invalid_a_i,
  input  logic [rrd_pkg::ChanBits-1:0]      red_b_i,
  input  logic [rrd_pkg::ChanBits-1:0]      green_b_i,
  input  logic [rrd_pkg::ChanBits-1:0]      blue_b_i,
  input  logic                              invalid_b_i,
  input  logic                              last_pixel_i,
  input  rrd_pkg::ctl_cmd_t                 cmd_i,
  output rrd_pkg::ctl_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rrd_pkg::RmsW-1:0]          rms_value_o,
  output logic                              no_valid_pairs_o,
  output logic [rrd_pkg::CntW-1:0]          valid_pairs_o
);

  localparam int ChanBits = rrd_pkg::ChanBits;
  localparam int SqW      = rrd_pkg::SqW;
  localparam int TermW    = rrd_pkg::TermW;
  localparam int SumW     = rrd_pkg::SumW;
  localparam int CntW     = rrd_pkg::CntW;
  localparam int DivW     = rrd_pkg::DivW;
  localparam int RootW    = rrd_pkg::RootW;
  localparam int RemW     = rrd_pkg::RemW;
  localparam int RmsW     = rrd_pkg::RmsW;

  // absolute channel differences and squares
  logic [ChanBits-1:0] diff_r, diff_g, diff_b;
  logic [SqW-1:0]      sq_r, sq_g, sq_b;
  logic [TermW-1:0]    term;

  always_comb begin
    diff_r = (red_a_i >= red_b_i) ? red_a_i - red_b_i : red_b_i - red_a_i;
    diff_g = (green_a_i >= green_b_i) ? green_a_i - green_b_i : green_b_i - green_a_i;
    diff_b = (blue_a_i >= blue_b_i) ? blue_a_i - blue_b_i : blue_b_i - blue_a_i;
    sq_r   = SqW'(diff_r) * SqW'(diff_r);
    sq_g   = SqW'(diff_g) * SqW'(diff_g);
    sq_b   = SqW'(diff_b) * SqW'(diff_b);
    term   = TermW'(sq_r) + TermW'(sq_g) + TermW'(sq_b);
  end

  // first stage: registered pair term and flags
  logic             s1_valid_q;
  logic             s1_ok_q;
  logic             s1_last_q;
  logic [TermW-1:0] s1_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      s1_ok_q   <= ~(invalid_a_i | invalid_b_i);
      s1_last_q <= last_pixel_i;
      s1_term_q <= term;
    end
  end

  // second stage: saturating sum and capped pair count
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW:0]   sum_add;

  always_comb begin
    sum_add = {1'b0, sum_q} + (SumW + 1)'(s1_term_q);
    sum_d   = sum_q;
    count_d = count_q;
    if (cmd_i.load) begin
      sum_d   = '0;
      count_d = '0;
    end else if (s1_valid_q && s1_ok_q && !count_q[CntW-1]) begin
      sum_d   = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // shared divide and square-root registers
  logic [DivW-1:0]  wrk_q, wrk_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  divisor_q;
  logic [CntW:0]    div_sh, div_diff;
  logic             div_ge;
  logic [RemW-1:0]  sq_sh, sq_trial, sq_diff;
  logic             sq_ge;

  always_comb begin
    div_sh   = {rem_q[CntW-1:0], wrk_q[DivW-1]};
    div_diff = div_sh - {1'b0, divisor_q};
    div_ge   = div_sh >= {1'b0, divisor_q};
    sq_sh    = {rem_q[RemW-3:0], wrk_q[DivW-1:DivW-2]};
    sq_trial = RemW'({root_q, 2'b01});
    sq_diff  = sq_sh - sq_trial;
    sq_ge    = sq_sh >= sq_trial;

    wrk_d  = wrk_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.load) begin
      wrk_d = {sum_q, {rrd_pkg::FracBits{1'b0}}};
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      wrk_d = {wrk_q[DivW-2:0], div_ge};
      rem_d = RemW'(div_ge ? div_diff[CntW-1:0] : div_sh[CntW-1:0]);
    end else if (cmd_i.sqrt_init) begin
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.sqrt_step) begin
      wrk_d  = {wrk_q[DivW-3:0], 2'b00};
      rem_d  = sq_ge ? sq_diff : sq_sh;
      root_d = {root_q[RootW-2:0], sq_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    wrk_q  <= wrk_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (cmd_i.load) begin
      divisor_q <= count_q;
    end
  end

  // output register
  logic            out_valid_q;
  logic [RmsW-1:0] rms_q;
  logic            none_q;
  logic [CntW-1:0] pairs_q;
  logic            root_big;

  assign root_big = |root_q[RootW-1:RmsW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (divisor_q == '0) begin
        rms_q   <= '0;
        none_q  <= 1'b1;
        pairs_q <= '0;
      end else begin
        rms_q   <= root_big ? {RmsW{1'b1}} : root_q[RmsW-1:0];
        none_q  <= 1'b0;
        pairs_q <= divisor_q;
      end
    end
  end

  assign sts_o.last_seen = s1_valid_q & s1_last_q;
  assign sts_o.out_busy  = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign rms_value_o      = rms_q;
  assign no_valid_pairs_o = none_q;
  assign valid_pairs_o    = pairs_q;

endmodule

// File: rtl/rrd_controller.sv
// end-of-image sequencer for the divide and square-root passes
module rrd_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrd_pkg::ctl_sts_t sts_i,
  output rrd_pkg::ctl_cmd_t cmd_o,
  output logic              in_stall_o
);

  localparam int StepW = rrd_pkg::StepW;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDiv,
    StPrep,
    StSqrt,
    StDone
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (sts_i.last_seen) begin
            state_q <= StLoad;
          end
        end
        StLoad: begin
          state_q <= StDiv;
          step_q  <= StepW'(rrd_pkg::DivW - 1);
        end
        StDiv: begin
          if (step_q == '0) begin
            state_q <= StPrep;
          end else begin
            step_q <= step_q - StepW'(1);
          end
        end
        StPrep: begin
          state_q <= StSqrt;
          step_q  <= StepW'(rrd_pkg::RootW - 1);
        end
        StSqrt: begin
          if (step_q == '0) begin
            state_q <= StDone;
          end else begin
            step_q <= step_q - StepW'(1);
          end
        end
        StDone: begin
          if (!sts_i.out_busy) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = state_q == StLoad;
    cmd_o.div_step  = state_q == StDiv;
    cmd_o.sqrt_init = state_q == StPrep;
    cmd_o.sqrt_step = state_q == StSqrt;
    cmd_o.emit      = (state_q == StDone) && !sts_i.out_busy;
  end

  // hold off requests from the last pair until the result is handed over
  assign in_stall_o = (state_q != StIdle) || sts_i.last_seen;

endmodule

// File: rtl/rgb_rms_difference.sv
// top level of the rgb root-mean-square difference block
//
// Input channel: one request per pixel pair (two RGB pixels, their invalid
// marks and the last_pixel flag), taken when in_valid_i is high and
// in_stall_o is low. Pairs with neither pixel invalid add their summed
// squared channel differences to a running sum and bump the pair count.
// Pairs are taken one per cycle while an image streams in.
// After the pair marked last_pixel is taken, in_stall_o stays high while a
// bit-serial divider (56 quotient bits, one per cycle) and an integer
// square root (28 root bits, one per cycle) run; the result request then
// appears on the output channel.
// Output channel: rms_value_o (Q9.8), no_valid_pairs_o and valid_pairs_o,
// held in an output register and taken when out_valid_o is high and
// out_stall_i is low. While the receiver stalls, the payload holds and the
// next image may stream in; a following result waits in the sequencer
// until the output register frees up.
// Reset clears the running sum, the count, the sequencer and both valid
// flags.
module rgb_rms_difference (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rrd_pkg::ChanBits-1:0] red_a_i,
  input  logic [rrd_pkg::ChanBits-1:0] green_a_i,
  input  logic [rrd_pkg::ChanBits-1:0] blue_a_i,
  input  logic                         invalid_a_i,
  input  logic [rrd_pkg::ChanBits-1:0] red_b_i,
  input  logic [rrd_pkg::ChanBits-1:0] green_b_i,
  input  logic [rrd_pkg::ChanBits-1:0] blue_b_i,
  input  logic                         invalid_b_i,
  input  logic                         last_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rrd_pkg::RmsW-1:0]     rms_value_o,
  output logic                         no_valid_pairs_o,
  output logic [rrd_pkg::CntW-1:0]     valid_pairs_o
);

  rrd_pkg::ctl_cmd_t cmd;
  rrd_pkg::ctl_sts_t sts;
  logic              in_accept;

  assign in_accept = in_valid_i & ~in_stall_o;

  // sequencer
  rrd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // arithmetic
  rrd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_accept_i      (in_accept),
    .red_a_i          (red_a_i),
    .green_a_i        (green_a_i),
    .blue_a_i         (blue_a_i),
    .invalid_a_i      (invalid_a_i),
    .red_b_i          (red_b_i),
    .green_b_i        (green_b_i),
    .blue_b_i         (blue_b_i),
    .invalid_b_i      (invalid_b_i),
    .last_pixel_i     (last_pixel_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rms_value_o      (rms_value_o),
    .no_valid_pairs_o (no_valid_pairs_o),
    .valid_pairs_o    (valid_pairs_o)
  );

endmodule
